// ===== src/tsc_pkg.sv =====
`timescale 1ns / 1ps

package tsc_pkg;

	// Angle and table geometry.
	localparam int ANGLE_BITS = 16;
	localparam int TABLE_BITS = 10;
	localparam int TAB_SIZE   = 1 << TABLE_BITS;
	localparam int QTR_BITS   = TABLE_BITS - 2;
	localparam int QTR_SIZE   = 1 << QTR_BITS;
	localparam int COS_W      = 17;
	localparam int PROD_W     = 26;
	localparam int POS_W      = 32;
	localparam int CNT_TURN_W = 16;
	localparam int DRIVE_W    = 9;

	// One third of a turn, rounded to the nearest angle unit.
	localparam logic [ANGLE_BITS-1:0] THIRD_TURN =
		ANGLE_BITS'(((1 << ANGLE_BITS) + 1) / 3);

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADV   = 3'd4;

	// Function codes carried in tuser.
	localparam logic [1:0] FUNC_POS = 2'd0;
	localparam logic [1:0] FUNC_INC = 2'd1;
	localparam logic [1:0] FUNC_SET = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_start;
		logic mul;
		logic upd;
		logic look;
		logic scale;
		logic fin;
	} tsc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
	} tsc_sts_t;

	typedef logic [QTR_SIZE-1:0][COS_W-1:0] qtr_tab_t;

	// Quarter-wave cosine in Q15 from an eleven-term Taylor series in Q30.
	function automatic logic signed [COS_W-1:0] quarter_cos(input int unsigned r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] q;
		logic signed [63:0] sum;
		int k;
		x    = (64'(r) * 64'd1686629713) / 64'(QTR_SIZE);
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = 64'sd1 <<< 30;
		for (k = 1; k <= 10; k++) begin
			term = (term * x2) >> 30;
			unique case (k)
				1:       term = term / 64'd2;
				2:       term = term / 64'd12;
				3:       term = term / 64'd30;
				4:       term = term / 64'd56;
				5:       term = term / 64'd90;
				6:       term = term / 64'd132;
				7:       term = term / 64'd182;
				8:       term = term / 64'd240;
				9:       term = term / 64'd306;
				default: term = term / 64'd380;
			endcase
			if (k % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = ($unsigned(sum) + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return COS_W'(q);
	endfunction

	// Quarter-wave table, one entry per step of the first quadrant.
	function automatic qtr_tab_t build_qtr_tab();
		qtr_tab_t t;
		for (int unsigned i = 0; i < QTR_SIZE; i++) begin
			t[i] = quarter_cos(i);
		end
		return t;
	endfunction

	localparam qtr_tab_t QTR_TAB = build_qtr_tab();

	// Value at exactly a quarter turn, reached only by the mirrored index.
	localparam logic signed [COS_W-1:0] QTR_END = quarter_cos(QTR_SIZE);

	// Full-wave cosine from the quarter wave by symmetry.
	function automatic logic signed [COS_W-1:0] cos_lookup(input logic [TABLE_BITS-1:0] idx);
		logic [QTR_BITS-1:0]     r;
		logic [QTR_BITS-1:0]     rm;
		logic signed [COS_W-1:0] up;
		logic signed [COS_W-1:0] dn;
		r  = idx[QTR_BITS-1:0];
		rm = '0 - r;
		up = QTR_TAB[r];
		dn = (r == '0) ? QTR_END : QTR_TAB[rm];
		unique case (idx[TABLE_BITS-1 -: 2])
			2'd0:    cos_lookup = up;
			2'd1:    cos_lookup = -dn;
			2'd2:    cos_lookup = -up;
			default: cos_lookup = dn;
		endcase
	endfunction

endpackage

// ===== src/three_phase_sine_commutator.sv =====
`timescale 1ns / 1ps

// Channel     Direction  Handshake                 Contents
// s_*         in         s_tvalid / s_tready       command word: function, position, step, angle
// m_*         out        m_tvalid / m_tready       result word: three phase drives, angle
// cfg_*       in         cfg_we (no wait)          register index and write data
//
// A position word passes through the remainder unit, which retires two bits of
// the 32-bit position per cycle, then the multiply, update, lookup, scale and
// output steps. Increment, set and unused function words skip the first two.
// One word is in work at a time; the next is taken once the previous has reached
// the output register, even while that result still waits for m_tready.
// Reset is asynchronous and active low, clears the angle and resets the config registers.
module three_phase_sine_commutator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,   // encoder_position, angle_step, angle_value
	input  logic [1:0]                    s_tuser,   // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [47:0]                   m_tdata,   // phase_a, phase_b, phase_c, angle_now, zeros
	input  logic                          cfg_we,
	input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsc_pkg::CFG_W-1:0]     cfg_data
);

	tsc_pkg::tsc_cmd_t cmd;
	tsc_pkg::tsc_sts_t sts;
	logic signed [tsc_pkg::DRIVE_W-1:0] phase_a, phase_b, phase_c;
	logic [15:0] angle_now;

	tsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.func     (s_tuser),
		.m_tready (m_tready),
		.sts      (sts),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	tsc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.func             (s_tuser),
		.encoder_position (s_tdata[31:0]),
		.angle_step       ($signed(s_tdata[47:32])),
		.angle_value      (s_tdata[63:48]),
		.phase_a          (phase_a),
		.phase_b          (phase_b),
		.phase_c          (phase_c),
		.angle_now        (angle_now)
	);

	// Pack the result word, first field in the lowest bits.
	assign m_tdata = {5'd0, angle_now, phase_c, phase_b, phase_a};

endmodule

// ===== src/tsc_div.sv =====
`timescale 1ns / 1ps

// Restoring remainder unit, two quotient bits per cycle.
module tsc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tsc_pkg::POS_W-1:0]        dividend,
	input  logic [tsc_pkg::CNT_TURN_W-1:0]   divisor,
	output logic                             done,
	output logic [tsc_pkg::CNT_TURN_W-1:0]   rem
);

	localparam int STEPS = tsc_pkg::POS_W / 2;
	localparam int CNT_W = $clog2(STEPS);
	localparam int REM_W = tsc_pkg::CNT_TURN_W + 1;

	logic [tsc_pkg::POS_W-1:0] num_q;
	logic [REM_W-1:0]          rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic [REM_W-1:0]          m;
	logic [REM_W:0]            t1;
	logic [REM_W:0]            t2;
	logic [REM_W:0]            r1;
	logic [REM_W:0]            r2;

	// A zero count per turn means a full 65536.
	assign m = (divisor == '0) ? REM_W'(1 << tsc_pkg::CNT_TURN_W) : {1'b0, divisor};

	// Two dependent compare-and-subtract steps.
	always_comb begin
		t1 = {rem_q, num_q[tsc_pkg::POS_W-1]};
		r1 = (t1 >= {1'b0, m}) ? t1 - {1'b0, m} : t1;
		t2 = {r1[REM_W-1:0], num_q[tsc_pkg::POS_W-2]};
		r2 = (t2 >= {1'b0, m}) ? t2 - {1'b0, m} : t2;
	end

	assign done = busy_q && (cnt_q == CNT_W'(STEPS - 1));
	assign rem  = rem_q[tsc_pkg::CNT_TURN_W-1:0];

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and remaining dividend bits.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 2;
			rem_q <= r2[REM_W-1:0];
		end
	end

endmodule

// ===== src/tsc_dp.sv =====
`timescale 1ns / 1ps

// Datapath: configuration, angle state, table lookup, scaling and rounding.
module tsc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tsc_pkg::tsc_cmd_t                  cmd,
	output tsc_pkg::tsc_sts_t                  sts,
	input  logic                               cfg_we,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsc_pkg::CFG_W-1:0]          cfg_data,
	input  logic [1:0]                         func,
	input  logic [tsc_pkg::POS_W-1:0]          encoder_position,
	input  logic signed [15:0]                 angle_step,
	input  logic [15:0]                        angle_value,
	output logic signed [tsc_pkg::DRIVE_W-1:0] phase_a,
	output logic signed [tsc_pkg::DRIVE_W-1:0] phase_b,
	output logic signed [tsc_pkg::DRIVE_W-1:0] phase_c,
	output logic [15:0]                        angle_now
);

	localparam int AB = tsc_pkg::ANGLE_BITS;
	localparam int TB = tsc_pkg::TABLE_BITS;

	// Configuration registers.
	logic [7:0]                        duty_q;
	logic                              dir_q;
	logic [tsc_pkg::CNT_TURN_W-1:0]    cpt_q;
	logic [15:0]                       gain_q;
	logic [14:0]                       adv_q;

	// Item and working registers.
	logic [1:0]                        func_q;
	logic signed [15:0]                step_q;
	logic [15:0]                       value_q;
	logic [AB-1:0]                     angle_q;
	logic [AB-1:0]                     mul_q;
	logic signed [tsc_pkg::COS_W-1:0]  cos_a_q, cos_b_q, cos_c_q;
	logic signed [tsc_pkg::PROD_W-1:0] prod_a_q, prod_b_q, prod_c_q;
	logic signed [tsc_pkg::DRIVE_W-1:0] phase_a_q, phase_b_q, phase_c_q;

	logic [tsc_pkg::CNT_TURN_W-1:0]    rem;
	logic [31:0]                       prod32;
	logic [AB-1:0]                     ang_b, ang_c;
	logic signed [9:0]                 duty_s;

	tsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (encoder_position),
		.divisor  (cpt_q),
		.done     (sts.div_done),
		.rem      (rem)
	);

	// Rounds half away from zero and saturates to 255, then restores the sign.
	function automatic logic signed [tsc_pkg::DRIVE_W-1:0] drive(
		input logic signed [tsc_pkg::PROD_W-1:0] p);
		logic [tsc_pkg::PROD_W-1:0] mag;
		logic [tsc_pkg::PROD_W-1:0] r;
		logic [tsc_pkg::DRIVE_W-1:0] m9;
		mag = p[tsc_pkg::PROD_W-1] ? tsc_pkg::PROD_W'(-p) : tsc_pkg::PROD_W'(p);
		r   = (mag + tsc_pkg::PROD_W'(16384)) >> 15;
		m9  = (r > tsc_pkg::PROD_W'(255)) ? 9'd255 : r[tsc_pkg::DRIVE_W-1:0];
		return p[tsc_pkg::PROD_W-1] ? tsc_pkg::DRIVE_W'(9'd0 - m9) : m9;
	endfunction

	assign prod32 = {16'd0, rem} * {16'd0, gain_q};
	assign ang_b  = angle_q - tsc_pkg::THIRD_TURN;
	assign ang_c  = angle_q + tsc_pkg::THIRD_TURN;
	assign duty_s = $signed({2'b00, duty_q});

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= 8'd0;
			dir_q  <= 1'b1;
			cpt_q  <= 16'd1024;
			gain_q <= 16'd64;
			adv_q  <= 15'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsc_pkg::REG_DUTY: duty_q <= cfg_data[7:0];
				tsc_pkg::REG_DIR:  dir_q  <= cfg_data[0];
				tsc_pkg::REG_CPT:  cpt_q  <= cfg_data;
				tsc_pkg::REG_GAIN: gain_q <= cfg_data;
				tsc_pkg::REG_ADV:  adv_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Electrical angle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (cmd.upd) begin
			unique case (func_q)
				tsc_pkg::FUNC_POS: begin
					if (dir_q) begin
						angle_q <= mul_q + AB'(adv_q);
					end else begin
						angle_q <= mul_q - AB'(adv_q);
					end
				end
				tsc_pkg::FUNC_INC: angle_q <= angle_q + AB'(step_q);
				tsc_pkg::FUNC_SET: angle_q <= AB'(value_q);
				default:           angle_q <= angle_q;
			endcase
		end
	end

	// Item capture, position scaling, lookup, scaling and output words.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			step_q  <= angle_step;
			value_q <= angle_value;
		end
		if (cmd.mul) begin
			mul_q <= prod32[AB-1:0];
		end
		if (cmd.look) begin
			cos_a_q <= tsc_pkg::cos_lookup(angle_q[AB-1 -: TB]);
			cos_b_q <= tsc_pkg::cos_lookup(ang_b[AB-1 -: TB]);
			cos_c_q <= tsc_pkg::cos_lookup(ang_c[AB-1 -: TB]);
		end
		if (cmd.scale) begin
			prod_a_q <= tsc_pkg::PROD_W'(duty_s) * tsc_pkg::PROD_W'(cos_a_q);
			prod_b_q <= tsc_pkg::PROD_W'(duty_s) * tsc_pkg::PROD_W'(cos_b_q);
			prod_c_q <= tsc_pkg::PROD_W'(duty_s) * tsc_pkg::PROD_W'(cos_c_q);
		end
		if (cmd.fin) begin
			phase_a_q <= drive(prod_a_q);
			phase_b_q <= drive(prod_b_q);
			phase_c_q <= drive(prod_c_q);
			angle_now <= 16'(angle_q);
		end
	end

	assign phase_a = phase_a_q;
	assign phase_b = phase_b_q;
	assign phase_c = phase_c_q;

endmodule

// ===== src/tsc_ctrl.sv =====
`timescale 1ns / 1ps

// Controller: sequences one word through the datapath and owns the handshakes.
module tsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [1:0]        func,
	input  logic              m_tready,
	input  tsc_pkg::tsc_sts_t sts,
	output logic              s_tready,
	output logic              m_tvalid,
	output tsc_pkg::tsc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_UPD,
		S_LOOK,
		S_SCALE,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   fin_fire;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd.load      = accept;
		cmd.div_start = accept && (func == tsc_pkg::FUNC_POS);
		cmd.mul       = (state_q == S_MUL);
		cmd.upd       = (state_q == S_UPD);
		cmd.look      = (state_q == S_LOOK);
		cmd.scale     = (state_q == S_SCALE);
		cmd.fin       = fin_fire;
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (func == tsc_pkg::FUNC_POS) ? S_DIV : S_UPD;
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_UPD;
				S_UPD:   state_q <= S_LOOK;
				S_LOOK:  state_q <= S_SCALE;
				S_SCALE: state_q <= S_FIN;
				S_FIN: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/tsc_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the commutator.
module tsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// A stalled result holds its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Only one word is in work: after an acceptance the input side closes.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// A new result only appears at the end of a busy period.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without work in progress");

	// Saturation never gives the code below -255.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] != 9'h100) && (m_tdata[17:9] != 9'h100)
			&& (m_tdata[26:18] != 9'h100))
		else $error("drive value out of range");

endmodule

bind three_phase_sine_commutator tsc_checker u_tsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
